// ----- rtl/assert_macros.svh -----
// Assertion macros for the RTL files that check their own logic
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset
`define ASSERT_CLK(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Check that a condition never holds on a rising clock edge outside reset
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);

`endif

// ----- rtl/bht_pkg.sv -----
// Shared types, constants and helper functions of the branch history table
package bht_pkg;

    // Table geometry (power-of-two depth: the masked index keeps the low bits)
    localparam int TABLE_DEPTH = 1024;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int TAG_W       = 32;
    localparam int CTR_W       = 2;
    localparam int TOTAL_W     = 32;
    localparam int CFG_W       = 32;
    localparam int ADDR_W      = 3;

    // Register indexes, selected by paddr[2]
    localparam logic REG_INDEX_BITS = 1'b0;
    localparam logic REG_WATCH_ADDR = 1'b1;

    // Command codes
    localparam logic CMD_BRANCH = 1'b0;
    localparam logic CMD_CLEAR  = 1'b1;

    // Counter extremes
    localparam logic [CTR_W-1:0] CTR_MAX = '1;
    localparam logic [CTR_W-1:0] CTR_MIN = '0;

    // One table entry: full address tag and 2-bit saturating counter
    typedef struct packed {
        logic [TAG_W-1:0] tag;
        logic [CTR_W-1:0] ctr;
    } bht_entry_t;

    // Outcome of evaluating one branch record against its entry
    typedef struct packed {
        logic             pred;
        logic             correct;
        logic             hit;
        logic [CTR_W-1:0] ctr_next;
    } bht_eval_t;

    // Control sequencer states
    typedef enum logic [2:0] {
        ST_CLEAR = 3'b001,
        ST_IDLE  = 3'b010,
        ST_EVAL  = 3'b100
    } bht_state_t;

    // Saturating increment of a running total
    function automatic logic [TOTAL_W-1:0] sat_inc(input logic [TOTAL_W-1:0] v);
        return (v == '1) ? v : v + TOTAL_W'(1);
    endfunction

    // Move a counter one step toward the outcome, holding at the ends
    function automatic logic [CTR_W-1:0] ctr_step(input logic [CTR_W-1:0] c,
                                                  input logic            tkn);
        logic [CTR_W-1:0] r;
        r = c;
        if (tkn) begin
            if (c != CTR_MAX) r = c + CTR_W'(1);
        end
        else begin
            if (c != CTR_MIN) r = c - CTR_W'(1);
        end
        return r;
    endfunction

endpackage

// ----- rtl/bht_table.sv -----
// Entry memory of the branch history table with its post-reset clearing sweep
module bht_table (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  rd_en,
    input  logic [bht_pkg::IDX_W-1:0] rd_addr,
    output bht_pkg::bht_entry_t   rd_data,
    input  logic                  wr_en,
    input  logic [bht_pkg::IDX_W-1:0] wr_addr,
    input  bht_pkg::bht_entry_t   wr_data,
    output logic                  ready
);
    import bht_pkg::*;

    bht_entry_t           mem [TABLE_DEPTH];
    bht_entry_t           rd_data_reg;
    logic                 clearing_reg;
    logic                 clearing_next;
    logic [IDX_W-1:0]     clr_idx_reg;
    logic [IDX_W-1:0]     clr_idx_next;
    logic                 mem_we;
    logic [IDX_W-1:0]     mem_wa;
    bht_entry_t           mem_wd;

    // Advance the clearing sweep one entry per cycle
    always_comb
    begin
        clearing_next = clearing_reg;
        clr_idx_next  = clr_idx_reg;
        if (clearing_reg) begin
            clr_idx_next = clr_idx_reg + IDX_W'(1);
            if (clr_idx_reg == IDX_W'(TABLE_DEPTH - 1)) clearing_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            clearing_reg <= 1'b1;
            clr_idx_reg  <= '0;
        end
        else begin
            clearing_reg <= clearing_next;
            clr_idx_reg  <= clr_idx_next;
        end
    end

    // Select the write source: sweep while clearing, else the update path
    always_comb
    begin
        mem_we = wr_en;
        mem_wa = wr_addr;
        mem_wd = wr_data;
        if (clearing_reg) begin
            mem_we = 1'b1;
            mem_wa = clr_idx_reg;
            mem_wd = '0;
        end
    end

    // Write port
    always_ff @(posedge clk)
    begin
        if (mem_we) mem[mem_wa] <= mem_wd;
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en) rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;
    assign ready   = !clearing_reg;

endmodule

// ----- rtl/branch_history_table_2bit_top.sv -----
// Top level of the direct-mapped 2-bit branch history table
//
// Usage: drive cmd, branch_address and taken with start high; the item is
// transferred at the rising edge where start is high and busy is low.
// cmd 0 is a branch record, cmd 1 clears the running totals (table kept).
// The transfer edge launches the table read. In the cycle after it
// the entry is evaluated and written back at the end of that cycle. The
// result is on the result ports with done high for exactly one cycle, set
// at the end of the update cycle; totals are shown after this item's update.
// Busy is high during the update cycle, so the next read comes after this
// item's write-back has landed.
// The receiver cannot stall: results must be taken in the done cycle.
// Reset: totals clear, index_bits returns to 10, watch_address to 0, and a
// clearing pass zeroes all 1024 table entries, one per cycle; busy stays
// high until the pass has ended. APB writes are taken throughout.
// Registers: index_bits at byte address 0, watch_address at byte address 4.
module branch_history_table_2bit_top (
    input  logic                      clk,
    input  logic                      rst_n,
    // command channel
    input  logic                      start,
    output logic                      busy,
    input  logic                      cmd,
    input  logic [31:0]               branch_address,
    input  logic                      taken,
    // result channel
    output logic                      done,
    output logic                      predicted_taken,
    output logic                      prediction_correct,
    output logic                      tag_hit,
    output logic [bht_pkg::TOTAL_W-1:0] hit_total,
    output logic [bht_pkg::TOTAL_W-1:0] miss_total,
    output logic [bht_pkg::TOTAL_W-1:0] correct_total,
    output logic [bht_pkg::TOTAL_W-1:0] mispredict_total,
    output logic [bht_pkg::TOTAL_W-1:0] watched_correct_total,
    // configuration port
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [bht_pkg::ADDR_W-1:0] paddr,
    input  logic [bht_pkg::CFG_W-1:0] pwdata,
    output logic [bht_pkg::CFG_W-1:0] prdata,
    output logic                      pready
);
    import bht_pkg::*;

    `include "assert_macros.svh"

    bht_state_t           state_reg;
    bht_state_t           state_next;
    logic                 accept;
    logic                 tbl_ready;

    logic [3:0]           index_bits_reg;
    logic [TAG_W-1:0]     watch_addr_reg;
    logic                 cfg_wr;

    logic                 cmd_reg;
    logic [TAG_W-1:0]     addr_reg;
    logic                 taken_reg;
    logic [IDX_W-1:0]     idx_reg;
    logic [IDX_W-1:0]     idx_mask;
    logic [IDX_W-1:0]     idx_in;

    bht_entry_t           rd_entry;
    bht_entry_t           wr_entry;
    logic                 wr_en;
    bht_eval_t            ev;

    logic [TOTAL_W-1:0]   hit_cnt_reg;
    logic [TOTAL_W-1:0]   miss_cnt_reg;
    logic [TOTAL_W-1:0]   corr_cnt_reg;
    logic [TOTAL_W-1:0]   misp_cnt_reg;
    logic [TOTAL_W-1:0]   wcorr_cnt_reg;

    logic                 done_reg;
    logic                 pred_reg;
    logic                 corr_reg;
    logic                 hit_reg;

    // Configuration registers
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            index_bits_reg <= 4'd10;
            watch_addr_reg <= '0;
        end
        else if (cfg_wr) begin
            case (paddr[2])
                REG_INDEX_BITS: index_bits_reg <= pwdata[3:0];
                REG_WATCH_ADDR: watch_addr_reg <= pwdata[TAG_W-1:0];
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            REG_INDEX_BITS: prdata = {{(CFG_W-4){1'b0}}, index_bits_reg};
            REG_WATCH_ADDR: prdata = watch_addr_reg;
            default:        prdata = '0;
        endcase
    end

    // Mask the low address bits by the active table size
    always_comb
    begin
        for (int i = 0; i < IDX_W; i++) begin
            idx_mask[i] = (i < int'(index_bits_reg));
        end
    end

    assign idx_in = branch_address[IDX_W-1:0] & idx_mask;

    // Control sequencer: wait for the clearing pass, then accept and evaluate
    assign accept = start && !busy;
    assign busy   = (state_reg != ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR: if (tbl_ready) state_next = ST_IDLE;
            ST_IDLE:  if (start)     state_next = ST_EVAL;
            ST_EVAL:                 state_next = ST_IDLE;
            default:                 state_next = ST_CLEAR;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= ST_CLEAR;
            done_reg  <= 1'b0;
        end
        else begin
            state_reg <= state_next;
            done_reg  <= (state_reg == ST_EVAL);
        end
    end

    // Hold the transferred item for the update cycle
    always_ff @(posedge clk)
    begin
        if (accept) begin
            cmd_reg   <= cmd;
            addr_reg  <= branch_address;
            taken_reg <= taken;
            idx_reg   <= idx_in;
        end
    end

    // Entry memory
    bht_table u_table (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (accept),
        .rd_addr (idx_in),
        .rd_data (rd_entry),
        .wr_en   (wr_en),
        .wr_addr (idx_reg),
        .wr_data (wr_entry),
        .ready   (tbl_ready)
    );

    // Evaluate the entry: predict, check, step the counter
    always_comb
    begin
        ev.pred     = rd_entry.ctr[CTR_W-1];
        ev.correct  = (ev.pred == taken_reg);
        ev.hit      = (rd_entry.tag == addr_reg);
        ev.ctr_next = ctr_step(rd_entry.ctr, taken_reg);
    end

    assign wr_en        = (state_reg == ST_EVAL) && (cmd_reg == CMD_BRANCH);
    assign wr_entry.tag = addr_reg;
    assign wr_entry.ctr = ev.ctr_next;

    // Update running totals, or drop them on a clear command
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            hit_cnt_reg   <= '0;
            miss_cnt_reg  <= '0;
            corr_cnt_reg  <= '0;
            misp_cnt_reg  <= '0;
            wcorr_cnt_reg <= '0;
        end
        else if (state_reg == ST_EVAL) begin
            if (cmd_reg == CMD_CLEAR) begin
                hit_cnt_reg   <= '0;
                miss_cnt_reg  <= '0;
                corr_cnt_reg  <= '0;
                misp_cnt_reg  <= '0;
                wcorr_cnt_reg <= '0;
            end
            else begin
                if (ev.hit) hit_cnt_reg  <= sat_inc(hit_cnt_reg);
                else        miss_cnt_reg <= sat_inc(miss_cnt_reg);
                if (ev.correct) begin
                    corr_cnt_reg <= sat_inc(corr_cnt_reg);
                    if (addr_reg == watch_addr_reg) wcorr_cnt_reg <= sat_inc(wcorr_cnt_reg);
                end
                else begin
                    misp_cnt_reg <= sat_inc(misp_cnt_reg);
                end
            end
        end
    end

    // Register the per-item result flags
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_EVAL) begin
            pred_reg <= (cmd_reg == CMD_BRANCH) && ev.pred;
            corr_reg <= (cmd_reg == CMD_BRANCH) && ev.correct;
            hit_reg  <= (cmd_reg == CMD_BRANCH) && ev.hit;
        end
    end

    assign done                  = done_reg;
    assign predicted_taken       = pred_reg;
    assign prediction_correct    = corr_reg;
    assign tag_hit               = hit_reg;
    assign hit_total             = hit_cnt_reg;
    assign miss_total            = miss_cnt_reg;
    assign correct_total         = corr_cnt_reg;
    assign mispredict_total      = misp_cnt_reg;
    assign watched_correct_total = wcorr_cnt_reg;

    // Self checks
    `ASSERT_CLK(a_accept_to_eval, clk, rst_n, accept |=> (state_reg == ST_EVAL) && !done_reg, "transfer did not enter the update cycle")
    `ASSERT_CLK(a_eval_to_done, clk, rst_n, (state_reg == ST_EVAL) |=> done_reg && !busy, "update cycle did not produce a result")
    `ASSERT_NEVER(a_no_accept_clearing, clk, rst_n, accept && !tbl_ready, "transfer taken during the clearing pass")
    `ASSERT_CLK(a_write_only_in_eval, clk, rst_n, wr_en |-> $past(accept), "table write without a preceding transfer")

endmodule
